// ===== rtl/ral_pkg.sv =====
// Package for the repeated activation lockout block.
// Holds register indexes, phase codes, state structs and defaults.
// No dependencies.
package ral_pkg;

  localparam int DEF_CHANNELS         = 2;
  localparam int DEF_TICKS_PER_SECOND = 40;

  localparam int CNT_W  = 14;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 8;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_EVAL_TIME    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_RELEASE_TIME = 3'd1;
  localparam logic [CFG_IW-1:0] REG_PEAK_COUNT   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_RELEASE_DROP = 3'd3;
  localparam logic [CFG_IW-1:0] REG_HOLD_TICKS   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_HOLD_ENABLE  = 3'd5;

  // channel phases
  localparam logic [1:0] PH_INIT = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_HIGH = 2'd3;

  // tick kinds
  localparam logic OP_AWAKE = 1'b0;
  localparam logic OP_SLEEP = 1'b1;

  typedef struct packed {
    logic [7:0] eval_time_s;
    logic [7:0] release_time_s;
    logic [7:0] peak_count;
    logic [7:0] release_drop;
    logic [7:0] hold_ticks;
    logic       hold_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    eval_time_s:    8'd10,
    release_time_s: 8'd10,
    peak_count:     8'd200,
    release_drop:   8'd10,
    hold_ticks:     8'd20,
    hold_enable:    1'b1
  };

  typedef struct packed {
    logic [1:0]       phase;
    logic [CNT_W-1:0] window_counter;
    logic [CNT_W-1:0] release_counter;
    logic [CNT_W-1:0] decay_counter;
    logic [7:0]       count_value;
    logic             lockout_flag;
    logic             configured_seen;
  } chan_t;

  localparam chan_t CHAN_RESET = '{
    phase:           PH_INIT,
    window_counter:  '0,
    release_counter: '0,
    decay_counter:   '0,
    count_value:     '0,
    lockout_flag:    1'b0,
    configured_seen: 1'b0
  };

  // one tick as seen by the update logic
  typedef struct packed {
    logic op;
    logic ch0;
    logic activation;
    logic configured;
    logic inductive_level;
  } tick_t;

endpackage

// ===== rtl/ral_step.sv =====
// Next-state logic for one channel on one tick, plus the channel 0 hold timer.
// Pure combinational; uses ral_pkg.
module ral_step #(
  parameter int TICKS_PER_SECOND = ral_pkg::DEF_TICKS_PER_SECOND
) (
  input  ral_pkg::cfg_t  cfg,
  input  ral_pkg::tick_t tick,
  input  ral_pkg::chan_t st_cur,
  input  logic [7:0]     hold_cur,
  input  logic           prev_cur,
  output ral_pkg::chan_t st_next,
  output logic [7:0]     hold_next,
  output logic           prev_next
);
  import ral_pkg::*;

  logic [CNT_W-1:0] eval_t;
  logic [CNT_W-1:0] release_t;
  logic             do_low;
  logic             do_high;
  logic             hold_on;
  logic [8:0]       n;
  chan_t            s;
  logic [7:0]       h;
  logic             p;

  assign eval_t    = CNT_W'(32'(cfg.eval_time_s) * TICKS_PER_SECOND);
  assign release_t = CNT_W'(32'(cfg.release_time_s) * TICKS_PER_SECOND);
  assign hold_on   = tick.ch0 && cfg.hold_enable;

  always_comb begin
    s       = st_cur;
    h       = hold_cur;
    p       = prev_cur;
    n       = '0;
    do_low  = 1'b0;
    do_high = 1'b0;

    if (tick.op == OP_AWAKE) begin
      if (!tick.configured && st_cur.configured_seen) begin
        s = CHAN_RESET;
      end
      s.configured_seen = tick.configured;
      if (tick.configured) begin
        case (st_cur.phase)
          PH_LOW:  do_low = 1'b1;
          PH_HIGH: do_high = 1'b1;
          default: s.phase = tick.activation ? PH_HIGH : PH_LOW;
        endcase
      end
    end else if (st_cur.configured_seen) begin
      if (st_cur.phase == PH_LOW) do_low = 1'b1;
      else do_high = 1'b1;
    end

    if (do_low) begin
      if (tick.activation) begin
        if (s.window_counter != '0) begin
          n = {1'b0, s.count_value} + 9'd1;
          s.window_counter = '0;
          s.decay_counter  = '0;
          if (n >= {1'b0, cfg.peak_count}) begin
            n = {1'b0, cfg.peak_count};
            s.lockout_flag    = 1'b1;
            s.release_counter = '0;
          end
          s.count_value = n[7:0];
        end
        s.phase = PH_HIGH;
        if (hold_on && s.lockout_flag) begin
          h = tick.inductive_level ? cfg.hold_ticks : 8'd0;
          p = tick.inductive_level;
        end
      end else begin
        if (s.window_counter != '0) s.window_counter = s.window_counter - CNT_W'(1);
        if (s.lockout_flag) begin
          if (s.release_counter != '0) begin
            s.release_counter = s.release_counter - CNT_W'(1);
            if (s.release_counter == '0) begin
              s.lockout_flag  = 1'b0;
              s.decay_counter = eval_t;
              s.count_value   = (s.count_value > cfg.release_drop) ?
                                s.count_value - cfg.release_drop : 8'd0;
            end
          end
        end else if (s.decay_counter != '0) begin
          s.decay_counter = s.decay_counter - CNT_W'(1);
          if (s.decay_counter == '0 && s.count_value != 8'd0) begin
            s.count_value = s.count_value - 8'd1;
            if (s.count_value != 8'd0) s.decay_counter = eval_t;
          end
        end
      end
    end

    if (do_high) begin
      if (tick.activation) begin
        if (hold_on) begin
          if (s.lockout_flag) begin
            if (tick.inductive_level) begin
              if (h != 8'd0) h = h - 8'd1;
              if (!p) h = cfg.hold_ticks;
            end else begin
              h = 8'd0;
            end
            p = tick.inductive_level;
          end else begin
            h = 8'd0;
          end
        end
      end else begin
        s.window_counter = eval_t;
        if (s.lockout_flag) s.release_counter = release_t;
        else s.decay_counter = eval_t;
        s.phase = PH_LOW;
        if (hold_on) h = 8'd0;
      end
    end

    st_next   = s;
    hold_next = h;
    prev_next = p;
  end

endmodule

// ===== rtl/repeated_activation_lockout.sv =====
// Repeated activation lockout: per-channel touch misuse lockout.
// Path: input register, then result register, which holds while m_axis_tready is low.
// Throughput: one tick per cycle while the output is not stalled; channel state is
// updated as a tick moves into the result register, so the next tick on the same
// channel sees it at once.
// Reset (rst, synchronous): registers to defaults, all channels initialized, hold timer 0.
// Uses ral_pkg and ral_step.
module repeated_activation_lockout #(
  parameter int CHANNELS         = ral_pkg::DEF_CHANNELS,
  parameter int TICKS_PER_SECOND = ral_pkg::DEF_TICKS_PER_SECOND
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // activation, configured, inductive_level
  input  logic [1:0]                 s_axis_tuser,  // op, channel
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [23:0]                m_axis_tdata,  // lockout_active, activation_count, hold_count
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ral_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ral_pkg::CFG_DW-1:0] cfg_data
);
  import ral_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cfg_t        cfg;
  chan_t       chan_st [CHANNELS];
  logic [7:0]  hold_timer;
  logic        prev_inductive;

  logic        in_valid;
  logic        in_op;
  logic        in_ch;
  logic        in_act;
  logic        in_cfg;
  logic        in_ind;

  logic        advance;
  logic        in_range;
  logic [CH_W-1:0] idx;
  tick_t       tick;
  chan_t       st_cur;
  chan_t       st_next;
  logic [7:0]  hold_next;
  logic        prev_next;

  logic        lockout_active;
  logic [7:0]  activation_count;
  logic [7:0]  hold_count;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EVAL_TIME:    cfg.eval_time_s    <= cfg_data;
        REG_RELEASE_TIME: cfg.release_time_s <= cfg_data;
        REG_PEAK_COUNT:   cfg.peak_count     <= cfg_data;
        REG_RELEASE_DROP: cfg.release_drop   <= cfg_data;
        REG_HOLD_TICKS:   cfg.hold_ticks     <= cfg_data;
        REG_HOLD_ENABLE:  cfg.hold_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !rst && (!in_valid || !m_axis_tvalid || m_axis_tready);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op  <= s_axis_tuser[0];
      in_ch  <= s_axis_tuser[1];
      in_act <= s_axis_tdata[0];
      in_cfg <= s_axis_tdata[1];
      in_ind <= s_axis_tdata[2];
    end
  end

  assign in_range = 32'(in_ch) < CHANNELS;
  assign idx      = CH_W'(in_ch);
  assign st_cur   = in_range ? chan_st[idx] : CHAN_RESET;

  assign tick.op              = in_op;
  assign tick.ch0             = !in_ch;
  assign tick.activation      = in_act;
  assign tick.configured      = in_cfg;
  assign tick.inductive_level = in_ind;

  ral_step #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_step (
    .cfg       (cfg),
    .tick      (tick),
    .st_cur    (st_cur),
    .hold_cur  (hold_timer),
    .prev_cur  (prev_inductive),
    .st_next   (st_next),
    .hold_next (hold_next),
    .prev_next (prev_next)
  );

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_st[i] <= CHAN_RESET;
      end
      hold_timer     <= 8'd0;
      prev_inductive <= 1'b0;
    end else if (advance && in_range) begin
      chan_st[idx]   <= st_next;
      hold_timer     <= hold_next;
      prev_inductive <= prev_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lockout_active   <= in_range ? st_next.lockout_flag : 1'b0;
      activation_count <= in_range ? st_next.count_value : 8'd0;
      hold_count       <= in_range ? hold_next : hold_timer;
    end
  end

  assign m_axis_tdata = {7'd0, hold_count, activation_count, lockout_active};

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for repeated_activation_lockout: directed table, then
// randomized config phases, checked word by word against typed table rows or an
// in-bench model. Depends on ral_pkg and the RTL top.
module testbench;
  import ral_pkg::*;

  localparam int TICKS = DEF_TICKS_PER_SECOND;

  typedef struct packed {
    logic       locked;
    logic [7:0] count;
    logic [7:0] hold;
  } status_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [2:0] reg_idx;
    logic [7:0] wdata;
    logic       op;
    logic       ch;
    logic       act;
    logic       cfgd;
    logic       ind;
    logic       typed;
    status_t    want;
  } dir_row_t;

  localparam status_t ZERO = '0;

  // typed rows come straight from reset defaults and obvious edge counts
  localparam dir_row_t DIRECTED[28] = '{
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_SLEEP, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
      '{1'b0, 8'd1, 8'd0}},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_SLEEP, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
      '{1'b0, 8'd1, 8'd0}},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_SLEEP, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
      '{1'b0, 8'd2, 8'd0}},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_SLEEP, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, ZERO},
    '{ROW_WRITE, REG_PEAK_COUNT,   8'd1,   OP_AWAKE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, ZERO},
    '{ROW_WRITE, REG_PEAK_COUNT,   8'd0,   OP_AWAKE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ZERO},
    '{ROW_WRITE, REG_RELEASE_TIME, 8'd0,   OP_AWAKE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, ZERO},
    '{ROW_WRITE, REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ZERO},
    '{ROW_WRITE, REG_HOLD_ENABLE,  8'd0,   OP_AWAKE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, ZERO},
    '{ROW_TICK,  REG_EVAL_TIME,    8'd0,   OP_AWAKE, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, ZERO}
  };

  localparam logic [2:0] REG_ORDER[6] = '{REG_EVAL_TIME, REG_RELEASE_TIME, REG_PEAK_COUNT,
                                          REG_RELEASE_DROP, REG_HOLD_TICKS, REG_HOLD_ENABLE};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  repeated_activation_lockout u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // lockout model state
  cfg_t        regs;
  logic [1:0]  chan_phase[2];
  logic [13:0] window_cnt[2];
  logic [13:0] release_cnt[2];
  logic [13:0] decay_cnt[2];
  logic [7:0]  touch_cnt[2];
  logic        locked[2];
  logic        seen_cfg[2];
  logic [7:0]  hold_cnt;
  logic        last_ind;

  status_t expected_status[$];
  int      fail_count = 0;

  // stimulus shaping
  logic act_level[2] = '{1'b0, 1'b0};
  int   run_left[2] = '{0, 0};
  logic ind_level = 1'b0;
  logic tx_calm = 1'b0;

  function automatic logic [13:0] secs_to_ticks(logic [7:0] secs);
    int t;
    t = int'(secs) * TICKS;
    return t[13:0];
  endfunction

  function automatic void rearm_channel(int c);
    window_cnt[c]  = '0;
    release_cnt[c] = '0;
    decay_cnt[c]   = '0;
    touch_cnt[c]   = '0;
    locked[c]      = 1'b0;
    chan_phase[c]  = PH_INIT;
  endfunction

  function automatic void low_tick(int c, logic act, logic ind);
    int n;
    if (act) begin
      if (window_cnt[c] != 0) begin
        n = int'(touch_cnt[c]) + 1;
        window_cnt[c] = '0;
        decay_cnt[c]  = '0;
        if (n >= int'(regs.peak_count)) begin
          n = int'(regs.peak_count);
          locked[c] = 1'b1;
          release_cnt[c] = '0;
        end
        touch_cnt[c] = n[7:0];
      end
      chan_phase[c] = PH_HIGH;
      if (c == 0 && regs.hold_enable && locked[0]) begin
        hold_cnt = ind ? regs.hold_ticks : 8'd0;
        last_ind = ind;
      end
      return;
    end
    if (window_cnt[c] != 0) window_cnt[c] = window_cnt[c] - 14'd1;
    if (locked[c]) begin
      if (release_cnt[c] != 0) begin
        release_cnt[c] = release_cnt[c] - 14'd1;
        if (release_cnt[c] == 0) begin
          locked[c] = 1'b0;
          decay_cnt[c] = secs_to_ticks(regs.eval_time_s);
          touch_cnt[c] = (touch_cnt[c] > regs.release_drop) ?
                         touch_cnt[c] - regs.release_drop : 8'd0;
        end
      end
    end else if (decay_cnt[c] != 0) begin
      decay_cnt[c] = decay_cnt[c] - 14'd1;
      if (decay_cnt[c] == 0 && touch_cnt[c] != 0) begin
        touch_cnt[c] = touch_cnt[c] - 8'd1;
        if (touch_cnt[c] != 0) decay_cnt[c] = secs_to_ticks(regs.eval_time_s);
      end
    end
  endfunction

  function automatic void high_tick(int c, logic act, logic ind);
    if (act) begin
      if (c == 0 && regs.hold_enable) begin
        if (locked[0]) begin
          if (ind) begin
            if (hold_cnt != 0) hold_cnt = hold_cnt - 8'd1;
            if (!last_ind) hold_cnt = regs.hold_ticks;
          end else begin
            hold_cnt = '0;
          end
          last_ind = ind;
        end else begin
          hold_cnt = '0;
        end
      end
      return;
    end
    window_cnt[c] = secs_to_ticks(regs.eval_time_s);
    if (locked[c]) release_cnt[c] = secs_to_ticks(regs.release_time_s);
    else decay_cnt[c] = secs_to_ticks(regs.eval_time_s);
    chan_phase[c] = PH_LOW;
    if (c == 0 && regs.hold_enable) hold_cnt = '0;
  endfunction

  function automatic status_t predict_tick(logic op, logic ch, logic act, logic cfgd,
                                           logic ind);
    int c;
    status_t r;
    c = int'(ch);
    if (op == OP_AWAKE) begin
      if (!cfgd && seen_cfg[c]) rearm_channel(c);
      seen_cfg[c] = cfgd;
      if (cfgd) begin
        if (chan_phase[c] == PH_LOW) low_tick(c, act, ind);
        else if (chan_phase[c] == PH_HIGH) high_tick(c, act, ind);
        else chan_phase[c] = act ? PH_HIGH : PH_LOW;
      end
    end else if (seen_cfg[c]) begin
      if (chan_phase[c] == PH_LOW) low_tick(c, act, ind);
      else high_tick(c, act, ind);
    end
    r.locked = locked[c];
    r.count  = touch_cnt[c];
    r.hold   = hold_cnt;
    return r;
  endfunction

  function automatic void reset_model();
    regs = CFG_RESET;
    for (int c = 0; c < 2; c++) begin
      rearm_channel(c);
      seen_cfg[c] = 1'b0;
    end
    hold_cnt = '0;
    last_ind = 1'b0;
  endfunction

  function automatic int pick_gap();
    if (tx_calm || $urandom_range(0, 9) < 7) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic cfg_t phase_plan(int p);
    cfg_t c;
    case (p)
      0: c = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1};
      1: c = '0;
      default: begin
        c.eval_time_s    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(1, 2));
        c.release_time_s = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 2));
        c.peak_count     = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(1, 6));
        c.release_drop   = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 4));
        c.hold_ticks     = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 5));
        c.hold_enable    = ($urandom_range(0, 3) != 0);
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] plan_value(cfg_t c, logic [2:0] idx);
    case (idx)
      REG_EVAL_TIME:    return c.eval_time_s;
      REG_RELEASE_TIME: return c.release_time_s;
      REG_PEAK_COUNT:   return c.peak_count;
      REG_RELEASE_DROP: return c.release_drop;
      REG_HOLD_TICKS:   return c.hold_ticks;
      REG_HOLD_ENABLE:  return {7'($urandom_range(0, 127)), c.hold_enable};
      default:          return '0;
    endcase
  endfunction

  // config writes only once every pending status word has come back
  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    s_axis_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_EVAL_TIME:    regs.eval_time_s    = data;
      REG_RELEASE_TIME: regs.release_time_s = data;
      REG_PEAK_COUNT:   regs.peak_count     = data;
      REG_RELEASE_DROP: regs.release_drop   = data;
      REG_HOLD_TICKS:   regs.hold_ticks     = data;
      REG_HOLD_ENABLE:  regs.hold_enable    = data[0];
      default: ;
    endcase
  endtask

  task automatic send_tick(logic op, logic ch, logic act, logic cfgd, logic ind,
                           logic typed, status_t want);
    status_t model;
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, ind, cfgd, act};
    s_axis_tuser  <= {ch, op};
    do @(posedge clk); while (!s_axis_tready);
    model = predict_tick(op, ch, act, cfgd, ind);
    expected_status.push_back(typed ? want : model);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender
  initial begin
    cfg_t plan;
    int k;
    logic op, ch, act, cfgd;
    reset_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE)
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].wdata);
      else
        send_tick(DIRECTED[i].op, DIRECTED[i].ch, DIRECTED[i].act, DIRECTED[i].cfgd,
                  DIRECTED[i].ind, DIRECTED[i].typed, DIRECTED[i].want);
    end
    for (int p = 0; p < 8; p++) begin
      plan = phase_plan(p);
      k = $urandom_range(0, 5);
      for (int r = 0; r < 6; r++)
        write_reg(REG_ORDER[(k + r) % 6], plan_value(plan, REG_ORDER[(k + r) % 6]));
      for (int n = 0; n < 225; n++) begin
        if ($urandom_range(0, 39) == 0) tx_calm = ~tx_calm;
        ch = 1'($urandom_range(0, 1));
        if (run_left[ch] == 0) begin
          act_level[ch] = ~act_level[ch];
          run_left[ch] = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 120)
                                                     : $urandom_range(1, 4);
        end
        run_left[ch]--;
        act  = ($urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1)) : act_level[ch];
        op   = ($urandom_range(0, 4) == 0) ? OP_SLEEP : OP_AWAKE;
        cfgd = ($urandom_range(0, 39) != 0);
        if ($urandom_range(0, 3) == 0) ind_level = ~ind_level;
        send_tick(op, ch, act, cfgd, ind_level, 1'b0, ZERO);
      end
    end
    s_axis_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // receiver backpressure, with one long hold-off to fill the pipeline
  int   hold_off = 0;
  int   rx_words = 0;
  logic long_hold_done = 1'b0;
  logic rx_calm = 1'b0;

  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) rx_words <= rx_words + 1;
    if ($urandom_range(0, 199) == 0) rx_calm <= ~rx_calm;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && rx_words >= 300) begin
      long_hold_done <= 1'b1;
      hold_off <= 400;
      m_axis_tready <= 1'b0;
    end else if (rx_calm || $urandom_range(0, 99) < 65) begin
      m_axis_tready <= 1'b1;
    end else begin
      hold_off <= ($urandom_range(0, 9) != 0) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      m_axis_tready <= 1'b0;
    end
  end

  // status word checker
  always @(posedge clk) begin
    status_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.locked = m_axis_tdata[0];
      got.count  = m_axis_tdata[8:1];
      got.hold   = m_axis_tdata[16:9];
      if (expected_status.size() == 0) begin
        $error("status word with none expected: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_status.pop_front();
        if (got.locked !== want.locked) begin
          $error("lockout_active: expected %0d, got %0d", want.locked, got.locked);
          fail_count++;
        end
        if (got.count !== want.count) begin
          $error("activation_count: expected %0d, got %0d", want.count, got.count);
          fail_count++;
        end
        if (got.hold !== want.hold) begin
          $error("hold_count: expected %0d, got %0d", want.hold, got.hold);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(64'd20_000_000);
    $display("testbench failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ral_pkg.sv
rtl/ral_step.sv
rtl/repeated_activation_lockout.sv
tb/sv/testbench.sv
